>>> hdl/rgt_pkg.sv
// rgt_pkg: shared types, widths and constants of the rainbow gradient tint core
// depends on nothing
package rgt_pkg;

  localparam int MAX_LINE = 4096;
  localparam int SPAN_W   = 13;
  localparam int POS_W    = 12;
  localparam int STEP_W   = 10;
  localparam int D_W      = 13;
  localparam int D2_W     = 25;
  localparam int W_W      = 37;
  localparam int SUM_W    = 40;
  localparam int REM_W    = 41;
  localparam int LUMA_W   = 24;
  localparam int QUO_W    = 18;
  localparam int TINT_W   = 17;
  localparam int N_ANCHOR = 6;
  localparam int N_PAIR   = 3;
  localparam int N_CHAN   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 13'd480;
  localparam logic [15:0] RECIP5_SPAN = 16'd52429;
  localparam logic [13:0] RECIP5_OUT  = 14'd13108;
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN = 2'd1;

  // anchor colours in halves, channel order r g b
  localparam logic [1:0] ANCHOR_HALF [N_ANCHOR][N_CHAN] = '{
    '{2'd2, 2'd0, 2'd0}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd2, 2'd0},
    '{2'd0, 2'd2, 2'd0}, '{2'd0, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd2}
  };

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pix_out_t;

  typedef struct packed {
    logic [N_CHAN-1:0][SUM_W-1:0] num;
    logic [SUM_W-1:0]             den;
    logic [LUMA_W-1:0]            luma;
  } div_beat_t;

  typedef struct packed {
    logic [N_CHAN-1:0][QUO_W-1:0] quo;
    logic [LUMA_W-1:0]            luma;
  } scale_beat_t;

  function automatic logic [SUM_W-1:0] half_mul(input logic [W_W-1:0] w,
                                                input logic [1:0] half);
    logic [SUM_W-1:0] res;
    case (half)
      2'd1:    res = SUM_W'(w);
      2'd2:    res = SUM_W'({w, 1'b0});
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/rgt_weight.sv
// rgt_weight: six-stage pipeline from pixel to anchor weight sums and luma
// depends on rgt_pkg
module rgt_weight (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  rgt_pkg::pix_in_t           in_pix,
  input  logic                       axis,
  input  logic [rgt_pkg::SPAN_W-1:0] span,
  output logic                       out_valid,
  output rgt_pkg::div_beat_t         out_beat
);

  logic [5:0] vld_r;

  // stage 1
  logic [rgt_pkg::SPAN_W-1:0] s_eff, s1_s_r;
  logic [rgt_pkg::POS_W-1:0]  pos_sel, s1_pos_nxt, s1_pos_r;
  logic [28:0]                step_prod;
  logic [rgt_pkg::STEP_W-1:0] s1_step_r;
  logic [7:0]                 s1_red_r, s1_green_r, s1_blue_r;

  // stage 2
  logic [rgt_pkg::N_ANCHOR-1:0][rgt_pkg::D_W-1:0] s2_d_nxt, s2_d_r;
  logic [rgt_pkg::LUMA_W-1:0] s2_luma_nxt, s2_luma_r;

  // stage 3, 4
  logic [rgt_pkg::N_ANCHOR-1:0][rgt_pkg::D_W-1:0]  s3_d_r;
  logic [rgt_pkg::N_ANCHOR-1:0][rgt_pkg::D2_W-1:0] s3_d2_r;
  logic [rgt_pkg::N_ANCHOR-1:0][rgt_pkg::W_W-1:0]  s4_w_r;
  logic [rgt_pkg::LUMA_W-1:0] s3_luma_r, s4_luma_r, s5_luma_r, s6_luma_r;

  // stage 5, 6
  logic [rgt_pkg::N_PAIR-1:0][rgt_pkg::N_CHAN-1:0][rgt_pkg::SUM_W-1:0] s5_acc_nxt, s5_acc_r;
  logic [rgt_pkg::N_PAIR-1:0][rgt_pkg::SUM_W-1:0] s5_den_nxt, s5_den_r;
  logic [rgt_pkg::N_CHAN-1:0][rgt_pkg::SUM_W-1:0] s6_num_nxt, s6_num_r;
  logic [rgt_pkg::SUM_W-1:0] s6_den_nxt, s6_den_r;

  always_comb begin
    if (span == '0) begin
      s_eff = rgt_pkg::SPAN_W'(1);
    end else if (span > rgt_pkg::SPAN_W'(rgt_pkg::MAX_LINE)) begin
      s_eff = rgt_pkg::SPAN_W'(rgt_pkg::MAX_LINE);
    end else begin
      s_eff = span;
    end
    pos_sel = axis ? in_pix.col : in_pix.row;
    if ({1'b0, pos_sel} >= s_eff) begin
      s1_pos_nxt = rgt_pkg::POS_W'(s_eff - rgt_pkg::SPAN_W'(1));
    end else begin
      s1_pos_nxt = pos_sel;
    end
    step_prod = 29'(s_eff) * 29'(rgt_pkg::RECIP5_SPAN);
  end

  always_comb begin
    logic [rgt_pkg::D_W-1:0] mid, dis, pos13;
    pos13 = {1'b0, s1_pos_r};
    for (int i = 0; i < rgt_pkg::N_ANCHOR; i++) begin
      mid = rgt_pkg::D_W'(s1_step_r) * rgt_pkg::D_W'(i);
      dis = (mid > pos13) ? mid - pos13 : pos13 - mid;
      s2_d_nxt[i] = s1_s_r - dis;
    end
    s2_luma_nxt = rgt_pkg::LUMA_W'(s1_red_r) * rgt_pkg::LUMA_W'(rgt_pkg::LUMA_R)
                + rgt_pkg::LUMA_W'(s1_green_r) * rgt_pkg::LUMA_W'(rgt_pkg::LUMA_G)
                + rgt_pkg::LUMA_W'(s1_blue_r) * rgt_pkg::LUMA_W'(rgt_pkg::LUMA_B);
  end

  // pairwise partial sums of the weighted anchor colours and of the weights, then their totals
  always_comb begin
    for (int p = 0; p < rgt_pkg::N_PAIR; p++) begin
      s5_den_nxt[p] = rgt_pkg::SUM_W'(s4_w_r[2*p]) + rgt_pkg::SUM_W'(s4_w_r[2*p+1]);
      for (int c = 0; c < rgt_pkg::N_CHAN; c++) begin
        s5_acc_nxt[p][c] = rgt_pkg::half_mul(s4_w_r[2*p], rgt_pkg::ANCHOR_HALF[2*p][c])
                         + rgt_pkg::half_mul(s4_w_r[2*p+1], rgt_pkg::ANCHOR_HALF[2*p+1][c]);
      end
    end
    s6_den_nxt = s5_den_r[0] + s5_den_r[1] + s5_den_r[2];
    for (int c = 0; c < rgt_pkg::N_CHAN; c++) begin
      s6_num_nxt[c] = s5_acc_r[0][c] + s5_acc_r[1][c] + s5_acc_r[2][c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
    s1_s_r     <= s_eff;
    s1_pos_r   <= s1_pos_nxt;
    s1_step_r  <= step_prod[27:18];
    s1_red_r   <= in_pix.red;
    s1_green_r <= in_pix.green;
    s1_blue_r  <= in_pix.blue;
    s2_d_r     <= s2_d_nxt;
    s2_luma_r  <= s2_luma_nxt;
    for (int i = 0; i < rgt_pkg::N_ANCHOR; i++) begin
      s3_d2_r[i] <= rgt_pkg::D2_W'(s2_d_r[i]) * rgt_pkg::D2_W'(s2_d_r[i]);
      s4_w_r[i]  <= rgt_pkg::W_W'(s3_d2_r[i]) * rgt_pkg::W_W'(s3_d_r[i]);
    end
    s3_d_r     <= s2_d_r;
    s3_luma_r  <= s2_luma_r;
    s4_luma_r  <= s3_luma_r;
    s5_acc_r   <= s5_acc_nxt;
    s5_den_r   <= s5_den_nxt;
    s5_luma_r  <= s4_luma_r;
    s6_num_r   <= s6_num_nxt;
    s6_den_r   <= s6_den_nxt;
    s6_luma_r  <= s5_luma_r;
  end

  assign out_valid     = vld_r[5];
  assign out_beat.num  = s6_num_r;
  assign out_beat.den  = s6_den_r;
  assign out_beat.luma = s6_luma_r;

endmodule

>>> hdl/rgt_div.sv
// rgt_div: pipelined restoring divider, one quotient bit per stage, three channels
// depends on rgt_pkg
module rgt_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rgt_pkg::div_beat_t   in_beat,
  output logic                 out_valid,
  output rgt_pkg::scale_beat_t out_beat
);

  localparam int NS = rgt_pkg::QUO_W;

  logic [NS:0] vld_r;
  logic [rgt_pkg::N_CHAN-1:0][rgt_pkg::REM_W-1:0] rem_r [NS];
  logic [rgt_pkg::N_CHAN-1:0][rgt_pkg::QUO_W-1:0] quo_r [1:NS];
  logic [rgt_pkg::SUM_W-1:0]  dd_r   [NS];
  logic [rgt_pkg::LUMA_W-1:0] luma_r [NS+1];

  logic [rgt_pkg::N_CHAN-1:0][rgt_pkg::REM_W-1:0] rem_nxt [NS];
  logic [rgt_pkg::N_CHAN-1:0][rgt_pkg::QUO_W-1:0] quo_nxt [NS];

  // divisor is twice the weight sum, the remainder stays below twice the divisor
  always_comb begin
    logic [rgt_pkg::REM_W-1:0] nr;
    logic                      ge;
    for (int j = 0; j < NS; j++) begin
      for (int c = 0; c < rgt_pkg::N_CHAN; c++) begin
        ge = rem_r[j][c] >= {1'b0, dd_r[j]};
        nr = ge ? rem_r[j][c] - {1'b0, dd_r[j]} : rem_r[j][c];
        rem_nxt[j][c] = {nr[rgt_pkg::REM_W-2:0], 1'b0};
        if (j == 0) begin
          quo_nxt[j][c] = rgt_pkg::QUO_W'(ge);
        end else begin
          quo_nxt[j][c] = {quo_r[j][c][rgt_pkg::QUO_W-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-1:0], in_valid};
    end
    for (int c = 0; c < rgt_pkg::N_CHAN; c++) begin
      rem_r[0][c] <= {1'b0, in_beat.num[c]};
    end
    dd_r[0]   <= {in_beat.den[rgt_pkg::SUM_W-2:0], 1'b0};
    luma_r[0] <= in_beat.luma;
    for (int j = 0; j < NS; j++) begin
      quo_r[j+1]  <= quo_nxt[j];
      luma_r[j+1] <= luma_r[j];
      if (j < NS - 1) begin
        rem_r[j+1] <= rem_nxt[j];
        dd_r[j+1]  <= dd_r[j];
      end
    end
  end

  assign out_valid     = vld_r[NS];
  assign out_beat.quo  = quo_r[NS];
  assign out_beat.luma = luma_r[NS];

endmodule

>>> hdl/rgt_scale.sv
// rgt_scale: three-stage luma times tint scaling with rounding and saturation
// depends on rgt_pkg
module rgt_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rgt_pkg::scale_beat_t in_beat,
  output logic                 out_valid,
  output rgt_pkg::pix_out_t    out_pix
);

  logic [2:0] vld_r;
  logic [rgt_pkg::N_CHAN-1:0][40:0] prod_nxt, prod_r;
  logic [rgt_pkg::N_CHAN-1:0][12:0] y_nxt, y_r;
  logic [rgt_pkg::N_CHAN-1:0][7:0]  res_nxt, res_r;

  always_comb begin
    logic [rgt_pkg::TINT_W-1:0] tint;
    logic [45:0] x;
    logic [26:0] qp;
    for (int c = 0; c < rgt_pkg::N_CHAN; c++) begin
      tint = rgt_pkg::TINT_W'((rgt_pkg::QUO_W'(in_beat.quo[c]) + rgt_pkg::QUO_W'(1)) >> 1);
      prod_nxt[c] = 41'(in_beat.luma) * 41'(tint);
      x = 46'(prod_r[c]) * 46'(12) + (46'(5) << 32);
      y_nxt[c] = x[45:33];
      qp = 27'(y_r[c]) * 27'(rgt_pkg::RECIP5_OUT);
      res_nxt[c] = (qp[26:16] > 11'd255) ? 8'd255 : qp[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
    prod_r <= prod_nxt;
    y_r    <= y_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid         = vld_r[2];
  assign out_pix.out_red   = res_r[0];
  assign out_pix.out_green = res_r[1];
  assign out_pix.out_blue  = res_r[2];

endmodule

>>> hdl/rainbow_gradient_tint_core.sv
// rainbow_gradient_tint_core: one pixel in per cycle, one tinted pixel out for each pixel in
// throughput one pixel per clock; busy stays low, out_strobe marks each result for one cycle
// latency is set by the 6 weight stages, the 19-stage divider and 3 scaling stages
// synchronous active-low reset clears the pipeline valid bits, axis to 0 and span to 480
// depends on rgt_pkg, rgt_weight, rgt_div, rgt_scale
module rainbow_gradient_tint_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rgt_pkg::pix_in_t              in_pix,
  output logic                          out_strobe,
  output rgt_pkg::pix_out_t             out_pix,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rgt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgt_pkg::SPAN_W-1:0]    cfg_data
);

  logic                       axis_r;
  logic [rgt_pkg::SPAN_W-1:0] span_r;
  logic                       div_in_valid, scale_in_valid;
  rgt_pkg::div_beat_t         div_in_beat;
  rgt_pkg::scale_beat_t       scale_in_beat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= 1'b0;
      span_r <= rgt_pkg::SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rgt_pkg::REG_AXIS: axis_r <= cfg_data[0];
        rgt_pkg::REG_SPAN: span_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rgt_weight u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_pix    (in_pix),
    .axis      (axis_r),
    .span      (span_r),
    .out_valid (div_in_valid),
    .out_beat  (div_in_beat)
  );

  rgt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_in_valid),
    .in_beat   (div_in_beat),
    .out_valid (scale_in_valid),
    .out_beat  (scale_in_beat)
  );

  rgt_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scale_in_valid),
    .in_beat   (scale_in_beat),
    .out_valid (out_strobe),
    .out_pix   (out_pix)
  );

endmodule
